// File: rtl/pma_pkg.sv
// Shared types, constants and helpers of the pin-mux allocator.
// Used by pin_mux_allocator_top and its testbench; depends on nothing.
package pma_pkg;

  localparam int unsigned PORT_COUNT_DEF       = 3;
  localparam int unsigned PINS_PER_PORT_DEF    = 16;
  localparam int unsigned REMAP_WORD_COUNT_DEF = 8;

  localparam logic [3:0] MODE_FLOATING_INPUT = 4'h4;
  localparam logic [5:0] ALT_USERS_MAX       = 6'd63;
  localparam logic [4:0] PORT_USERS_MAX      = 5'd31;

  // Request kinds.
  localparam logic MODE_CLAIM   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PORT  = 3'd1,
    ST_PIN_BUSY  = 3'd2,
    ST_PIN_FREE  = 3'd3,
    ST_REMAP_BAD = 3'd4,
    ST_ALT_UNDER = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_EXEC = 2'b10
  } fsm_e;

  typedef struct packed {
    logic       mode;
    logic [1:0] port_index;
    logic [3:0] pin_number;
    logic [3:0] pin_function;
    logic       remap_present;
    logic [2:0] remap_word;
    logic [4:0] field_position;
    logic [3:0] field_width;
    logic [3:0] remap_value;
  } req_t;

  // Alternate function: bit 3 set and the two low bits not both zero.
  function automatic logic is_alternate(input logic [3:0] f);
    return f[3] && (f[1:0] != 2'b00);
  endfunction

endpackage

// File: rtl/pma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instanced by pin_mux_allocator_top.
module pma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pin_mux_allocator_top.sv
// Pin-mux allocator: claims and releases pins of several GPIO ports.
// Requests are registered at accept; the result is registered when the EXEC state
// fires with the output register free. A new request is taken only once the last one has executed, as the
// pin-mode RAM and the remap-word RAM are read at accept and written back in EXEC.
// Reset clears ownership, user counts and remap valid bits at once; no RAM sweep
// is needed, since an unowned pin or an unwritten remap word reads as its reset value.
// Depends on pma_pkg and pma_ram.
module pin_mux_allocator_top #(
  parameter int unsigned PORT_COUNT       = pma_pkg::PORT_COUNT_DEF,
  parameter int unsigned PINS_PER_PORT    = pma_pkg::PINS_PER_PORT_DEF,
  parameter int unsigned REMAP_WORD_COUNT = pma_pkg::REMAP_WORD_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [1:0]  port_index_i,
  input  logic [3:0]  pin_number_i,
  input  logic [3:0]  pin_function_i,
  input  logic        remap_present_i,
  input  logic [2:0]  remap_word_i,
  input  logic [4:0]  field_position_i,
  input  logic [3:0]  field_width_i,
  input  logic [3:0]  remap_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  port_clocks_o,
  output logic        alt_clock_o,
  output logic [3:0]  mode_nibble_o,
  output logic [31:0] remap_contents_o
);

  localparam int unsigned PIN_DEPTH = PORT_COUNT * PINS_PER_PORT;
  localparam int unsigned PA_W   = (PIN_DEPTH > 1) ? $clog2(PIN_DEPTH) : 1;
  localparam int unsigned RW_W   = (REMAP_WORD_COUNT > 1) ? $clog2(REMAP_WORD_COUNT) : 1;
  localparam int unsigned PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int unsigned PIN_W  = $clog2(PINS_PER_PORT);

  pma_pkg::fsm_e state_q, state_d;
  pma_pkg::req_t req_q;

  logic [PINS_PER_PORT-1:0] pin_owned_q [PORT_COUNT];
  logic [PINS_PER_PORT-1:0] pin_owned_d [PORT_COUNT];
  logic [4:0]               users_q     [PORT_COUNT];
  logic [4:0]               users_d     [PORT_COUNT];
  logic [5:0]               alt_q, alt_d;
  logic [REMAP_WORD_COUNT-1:0] remap_vld_q, remap_vld_d;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [2:0]  clocks_q;
  logic        alt_clock_q;
  logic [3:0]  nibble_q;
  logic [31:0] remap_out_q;

  // Accept side: address the RAMs straight from the request ports.
  logic            accept;
  logic            in_pin_ok, in_word_ok;
  logic [7:0]      in_idx;
  assign in_ready_o = (state_q == pma_pkg::FSM_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_pin_ok  = (32'(port_index_i) < PORT_COUNT) && (32'(pin_number_i) < PINS_PER_PORT);
  assign in_word_ok = 32'(remap_word_i) < REMAP_WORD_COUNT;
  assign in_idx     = 8'(port_index_i) * 8'(PINS_PER_PORT) + 8'(pin_number_i);

  // Execute side.
  logic            exec_go;
  logic            pin_ok, word_ok, owned, alt_fn, claim_ok, rel_ok;
  logic [PORT_W-1:0] psel;
  logic [PIN_W-1:0]  pbit;
  logic [RW_W-1:0]   wsel;
  logic [7:0]        idx;
  logic [3:0]        mode_rdata, cur_mode, new_mode;
  logic [31:0]       remap_rdata, cur_word, new_word;
  logic [14:0]       fmask;
  logic [31:0]       mask32, field, val32;
  logic [2:0]        status;
  logic [2:0]        clocks;

  assign exec_go = (state_q == pma_pkg::FSM_EXEC) && (!out_valid_q || out_ready_i);
  assign pin_ok  = (32'(req_q.port_index) < PORT_COUNT) &&
                   (32'(req_q.pin_number) < PINS_PER_PORT);
  assign word_ok = 32'(req_q.remap_word) < REMAP_WORD_COUNT;
  assign psel    = pin_ok ? req_q.port_index[PORT_W-1:0] : '0;
  assign pbit    = pin_ok ? req_q.pin_number[PIN_W-1:0] : '0;
  assign wsel    = word_ok ? req_q.remap_word[RW_W-1:0] : '0;
  assign idx     = 8'(req_q.port_index) * 8'(PINS_PER_PORT) + 8'(req_q.pin_number);
  assign owned   = pin_owned_q[psel][pbit];
  assign alt_fn  = pma_pkg::is_alternate(req_q.pin_function);

  // An unowned pin always sits at floating input, so ownership doubles as valid bit.
  assign cur_mode = owned ? mode_rdata : pma_pkg::MODE_FLOATING_INPUT;
  assign cur_word = remap_vld_q[wsel] ? remap_rdata : 32'd0;

  assign fmask  = (req_q.field_width == 4'd0) ? 15'd0 :
                  15'((16'd1 << req_q.field_width) - 16'd1);
  assign mask32 = {17'd0, fmask} << req_q.field_position;
  assign field  = (cur_word >> req_q.field_position) & {17'd0, fmask};
  assign val32  = {28'd0, req_q.remap_value};

  always_comb begin
    status   = pma_pkg::ST_OK;
    claim_ok = 1'b0;
    rel_ok   = 1'b0;
    if (!pin_ok || (req_q.remap_present && !word_ok)) begin
      status = pma_pkg::ST_BAD_PORT;
    end else if (req_q.mode == pma_pkg::MODE_CLAIM) begin
      if (owned) begin
        status = pma_pkg::ST_PIN_BUSY;
      end else begin
        claim_ok = 1'b1;
      end
    end else if (!owned) begin
      status = pma_pkg::ST_PIN_FREE;
    end else if (req_q.remap_present && (field != val32)) begin
      status = pma_pkg::ST_REMAP_BAD;
    end else if (alt_fn && (alt_q == 6'd0)) begin
      status = pma_pkg::ST_ALT_UNDER;
    end else begin
      rel_ok = 1'b1;
    end
  end

  always_comb begin
    new_mode    = cur_mode;
    new_word    = cur_word;
    pin_owned_d = pin_owned_q;
    users_d     = users_q;
    alt_d       = alt_q;
    remap_vld_d = remap_vld_q;
    if (claim_ok) begin
      new_mode = req_q.pin_function;
      pin_owned_d[psel][pbit] = 1'b1;
      if (users_q[psel] < pma_pkg::PORT_USERS_MAX) begin
        users_d[psel] = users_q[psel] + 5'd1;
      end
      if (alt_fn && (alt_q < pma_pkg::ALT_USERS_MAX)) begin
        alt_d = alt_q + 6'd1;
      end
      if (req_q.remap_present) begin
        new_word = (cur_word & ~mask32) | ((val32 << req_q.field_position) & mask32);
        remap_vld_d[wsel] = 1'b1;
      end
    end else if (rel_ok) begin
      new_mode = pma_pkg::MODE_FLOATING_INPUT;
      pin_owned_d[psel][pbit] = 1'b0;
      if (users_q[psel] != 5'd0) begin
        users_d[psel] = users_q[psel] - 5'd1;
      end
      if (alt_fn) begin
        alt_d = alt_q - 6'd1;
      end
      if (req_q.remap_present) begin
        new_word = cur_word & ~mask32;
        remap_vld_d[wsel] = 1'b1;
      end
    end
  end

  for (genvar p = 0; p < 3; p++) begin : g_clk
    if (p < PORT_COUNT) begin : g_on
      assign clocks[p] = (users_d[p] != 5'd0);
    end else begin : g_off
      assign clocks[p] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pma_pkg::FSM_IDLE: begin
        if (accept) state_d = pma_pkg::FSM_EXEC;
      end
      pma_pkg::FSM_EXEC: begin
        if (exec_go) state_d = pma_pkg::FSM_IDLE;
      end
      default: state_d = pma_pkg::FSM_IDLE;
    endcase
  end

  pma_ram #(
    .WIDTH(4),
    .DEPTH(PIN_DEPTH)
  ) u_mode_ram (
    .clk_i   (clk_i),
    .we_i    (exec_go && (claim_ok || rel_ok)),
    .waddr_i (idx[PA_W-1:0]),
    .wdata_i (new_mode),
    .re_i    (accept && in_pin_ok),
    .raddr_i (in_idx[PA_W-1:0]),
    .rdata_o (mode_rdata)
  );

  pma_ram #(
    .WIDTH(32),
    .DEPTH(REMAP_WORD_COUNT)
  ) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (exec_go && req_q.remap_present && (claim_ok || rel_ok)),
    .waddr_i (wsel),
    .wdata_i (new_word),
    .re_i    (accept && in_word_ok),
    .raddr_i (remap_word_i[RW_W-1:0]),
    .rdata_o (remap_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pma_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
      alt_q       <= '0;
      remap_vld_q <= '0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        pin_owned_q[i] <= '0;
        users_q[i]     <= '0;
      end
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
        pin_owned_q <= pin_owned_d;
        users_q     <= users_d;
        alt_q       <= alt_d;
        remap_vld_q <= remap_vld_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= '{mode:           mode_i,
                 port_index:     port_index_i,
                 pin_number:     pin_number_i,
                 pin_function:   pin_function_i,
                 remap_present:  remap_present_i,
                 remap_word:     remap_word_i,
                 field_position: field_position_i,
                 field_width:    field_width_i,
                 remap_value:    remap_value_i};
    end
    if (exec_go) begin
      status_q    <= status;
      clocks_q    <= clocks;
      alt_clock_q <= (alt_d != 6'd0);
      nibble_q    <= pin_ok ? new_mode : 4'd0;
      remap_out_q <= word_ok ? new_word : 32'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign port_clocks_o    = clocks_q;
  assign alt_clock_o      = alt_clock_q;
  assign mode_nibble_o    = nibble_q;
  assign remap_contents_o = remap_out_q;

endmodule
